/* rtl/pixel_invert_or_gamma_grayscale_macros.svh */
// Assertion helpers used by the pixel pipeline RTL file.
`ifndef PIXEL_INVERT_OR_GAMMA_GRAYSCALE_MACROS_SVH
`define PIXEL_INVERT_OR_GAMMA_GRAYSCALE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIGG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIGG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pigg_pkg.sv */
`default_nettype none

package pigg_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pigg_pix_in_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } pigg_pix_out_type;

   localparam logic [1:0] MODE_PASS   = 2'd0;
   localparam logic [1:0] MODE_INVERT = 2'd1;
   localparam logic [1:0] MODE_GRAY   = 2'd2;

   // Luma weights scaled by 10000; the weighted sum of three bytes fits 22 bits.
   localparam int unsigned SUM_W    = 22;
   localparam int unsigned WEIGHT_R = 2126;
   localparam int unsigned WEIGHT_G = 7152;
   localparam int unsigned WEIGHT_B = 722;

   // Full scale 255 * 10000 = 2550000 = 16 * 159375.
   localparam int unsigned DIV_SHIFT = 4;
   localparam int unsigned DIV_ODD   = 159375;
   localparam int unsigned DIV_W     = 18;

   localparam int unsigned GRAY_W      = 8;
   localparam int unsigned GRAY_LEVELS = 256;

   // True when floor(255 * c(y / 2^f)) >= v, evaluated exactly.
   function automatic logic curve_ge(input longint unsigned y, input int unsigned v,
                                     input int unsigned f);
      logic [383:0]    lhs;
      logic [383:0]    rhs;
      longint unsigned one;
      begin
         one = 64'd1 << f;
         if (y * 64'd10000000 <= (64'd31308 << f)) begin
            return (64'd32946 * y) >= (64'(v) * 64'd10 * one);
         end
         lhs = 384'd1;
         for (int k = 0; k < 5; k++) lhs = lhs * 384'(y);
         for (int k = 0; k < 12; k++) lhs = lhs * 384'd10761;
         rhs = 384'd1;
         for (int k = 0; k < 12; k++) rhs = rhs * 384'(40 * v + 561);
         for (int k = 0; k < 5; k++) rhs = rhs * 384'(one);
         return lhs >= rhs;
      end
   endfunction

   // Smallest luma code whose curve entry reaches grey level v.
   function automatic logic [31:0] pigg_threshold(input int unsigned v, input int unsigned f);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      begin
         lo = 64'd0;
         hi = 64'd1 << f;
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (curve_ge(mid, v, f)) begin
               hi = mid;
            end else begin
               lo = mid + 64'd1;
            end
         end
         return 32'(lo);
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/pixel_invert_or_gamma_grayscale.sv */
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-----------------------------------
// req_      | in        | req_valid/req_stall  | req_data: red, green, blue
// rsp_      | out       | rsp_valid/rsp_stall  | rsp_data: red_out, green_out, blue_out
// csr_      | in        | csr_wr_en            | csr_wr_data: mode
//
// One item can enter per clock while req_stall is low. The stages are the weighted sum,
// the luma divider, the search of the gamma threshold table and the output register.
// Reset is synchronous and clears the valid bits and the mode register. A stall on the
// result side freezes only the full stages that cannot move on, so bubbles close up
// and input items are still taken while a finished result waits in the output
// register, as long as some stage ahead of them is empty.
`default_nettype none
`include "pixel_invert_or_gamma_grayscale_macros.svh"

module pixel_invert_or_gamma_grayscale #(
   parameter int unsigned LUMA_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  pigg_pkg::pigg_pix_in_type  req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output pigg_pkg::pigg_pix_out_type rsp_data,
   input  logic                       csr_wr_en,
   input  logic [1:0]                 csr_wr_data
);
   import pigg_pkg::*;

   // Luma is unsigned Q1.F, so white reads as exactly one.
   localparam int unsigned YW      = LUMA_FRAC_BITS + 1;
   // The division numerator is sum * 2^(F-4) and the divisor the odd part of full scale.
   localparam int unsigned NUM_W   = SUM_W + LUMA_FRAC_BITS - DIV_SHIFT;
   localparam int unsigned RECIP_W = YW;
   localparam int unsigned PROD_W  = SUM_W + RECIP_W;
   localparam int unsigned QD_W    = YW + DIV_W;
   localparam int unsigned PAD_W   = LUMA_FRAC_BITS - DIV_SHIFT;
   // Reciprocal scaled by 2^NUM_W: since the sum stays below 2^SUM_W, the
   // estimated quotient is at most one short of the true one.
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << NUM_W) / 64'(DIV_ODD));
   localparam logic [YW-1:0]      Y_ONE = YW'(1) << LUMA_FRAC_BITS;

   // Stage map: 0 weighted sum, 1 reciprocal product, 2 quotient and back
   // product, 3 corrected luma, 4..11 threshold search, 12 output register.
   localparam int unsigned NS    = 13;
   localparam int unsigned LAST  = NS - 1;
   localparam int unsigned SRCH0 = 4;
   localparam int unsigned SRCHN = GRAY_W;

   logic [NS-1:0]         vld_ff;
   logic [NS-1:0]         vld_in;
   logic [NS-1:0]         en;
   pigg_pix_in_type       pix_ff [0:LAST-1];
   logic [SUM_W-1:0]      sum_ff [0:2];
   logic [SUM_W-1:0]      sum_in;
   logic [PROD_W-1:0]     prod_ff;
   logic [PROD_W-1:0]     prod_in;
   logic [YW-1:0]         q_ff;
   logic [YW-1:0]         q_in;
   logic [NUM_W-1:0]      qd_ff;
   logic [NUM_W-1:0]      qd_in;
   logic [QD_W-1:0]       qd_full;
   logic [NUM_W-1:0]      num_c;
   logic [NUM_W-1:0]      rem_c;
   logic [YW-1:0]         y_in;
   logic [YW-1:0]         y_ff   [SRCH0-1:LAST-1];
   logic [GRAY_W-1:0]     pre_ff [SRCH0-1:LAST-1];
   logic [YW-1:0]         thr_tbl [GRAY_LEVELS];
   logic [1:0]            mode_ff;
   logic [1:0]            mode_in;
   pigg_pix_out_type      out_ff;
   pigg_pix_out_type      out_in;
   logic [GRAY_W-1:0]     gray_c;

   // Mode register; the user must write it only while the pipeline is empty, since the block does no check.
   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PASS;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // A stage may load when it is empty or when the stage after it loads.
   always_comb begin
      en[LAST] = !vld_ff[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = en[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < NS; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[LAST];
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // The original pixel rides along for the pass-through and invert modes.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         pix_ff[0] <= req_data;
      end
      for (int i = 1; i < LAST; i++) begin
         if (en[i]) begin
            pix_ff[i] <= pix_ff[i-1];
         end
      end
   end

   // Stage 0: Rec.709 weighted sum of the three bytes.
   assign sum_in = SUM_W'(req_data.red)   * SUM_W'(WEIGHT_R)
                 + SUM_W'(req_data.green) * SUM_W'(WEIGHT_G)
                 + SUM_W'(req_data.blue)  * SUM_W'(WEIGHT_B);

   // Stage 1: multiply by the reciprocal of the divisor.
   assign prod_in = PROD_W'(sum_ff[0]) * PROD_W'(RECIP);

   // Stage 2: quotient estimate and its product with the divisor.
   assign q_in    = prod_ff[PROD_W-1:SUM_W];
   assign qd_full = QD_W'(q_in) * QD_W'(DIV_ODD);
   assign qd_in   = qd_full[NUM_W-1:0];

   // Stage 3: the remainder tells whether the estimate was one short.
   assign num_c = {sum_ff[2], {PAD_W{1'b0}}};
   assign rem_c = num_c - qd_ff;
   assign y_in  = q_ff + YW'(rem_c >= NUM_W'(DIV_ODD));

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sum_ff[0] <= sum_in;
      end
      if (en[1]) begin
         sum_ff[1] <= sum_ff[0];
         prod_ff   <= prod_in;
      end
      if (en[2]) begin
         sum_ff[2] <= sum_ff[1];
         q_ff      <= q_in;
         qd_ff     <= qd_in;
      end
      if (en[SRCH0-1]) begin
         y_ff[SRCH0-1]   <= y_in;
         pre_ff[SRCH0-1] <= '0;
      end
   end

   // Threshold table: entry v is the smallest luma code whose encoded grey
   // level reaches v. The curve rises with luma, so the grey level is the
   // largest v whose threshold does not exceed the luma.
   for (genvar gv = 0; gv < GRAY_LEVELS; gv++) begin : g_thr
      localparam logic [31:0] THR = pigg_threshold(gv, LUMA_FRAC_BITS);
      assign thr_tbl[gv] = THR[YW-1:0];
   end

   // Binary search over the table, one grey bit per stage from the top down.
   for (genvar s = 0; s < SRCHN; s++) begin : g_srch
      logic [GRAY_W-1:0] cand;
      logic [GRAY_W-1:0] pre_in;

      assign cand   = pre_ff[SRCH0-1+s] | (GRAY_W'(1) << (GRAY_W - 1 - s));
      assign pre_in = (thr_tbl[cand] <= y_ff[SRCH0-1+s]) ? cand : pre_ff[SRCH0-1+s];

      always_ff @(posedge clock) begin
         if (en[SRCH0+s]) begin
            pre_ff[SRCH0+s] <= pre_in;
            y_ff[SRCH0+s]   <= y_ff[SRCH0-1+s];
         end
      end
   end

   // Output stage: pick the result by mode; mode 3 behaves like pass-through.
   assign gray_c = pre_ff[LAST-1];

   always_comb begin
      unique case (mode_ff)
         MODE_INVERT: begin
            out_in.red_out   = ~pix_ff[LAST-1].red;
            out_in.green_out = ~pix_ff[LAST-1].green;
            out_in.blue_out  = ~pix_ff[LAST-1].blue;
         end
         MODE_GRAY: begin
            out_in.red_out   = gray_c;
            out_in.green_out = gray_c;
            out_in.blue_out  = gray_c;
         end
         default: begin
            out_in.red_out   = pix_ff[LAST-1].red;
            out_in.green_out = pix_ff[LAST-1].green;
            out_in.blue_out  = pix_ff[LAST-1].blue;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         out_ff <= out_in;
      end
   end

   `PIGG_ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && !req_stall, vld_ff[0],
      "accepted item did not enter stage 0")
   `PIGG_ASSERT_NOW(a_rem_bound, clock, reset, vld_ff[2], rem_c < NUM_W'(2 * DIV_ODD),
      "quotient estimate off by more than one")
   `PIGG_ASSERT_NOW(a_luma_range, clock, reset, vld_ff[SRCH0-1], y_ff[SRCH0-1] <= Y_ONE,
      "luma above full scale")
   `PIGG_ASSERT_NOW(a_search_found, clock, reset, vld_ff[LAST-1],
      thr_tbl[pre_ff[LAST-1]] <= y_ff[LAST-1], "grey level threshold above luma")
   `PIGG_ASSERT_NOW(a_gray_equal, clock, reset, rsp_valid && mode_ff == MODE_GRAY,
      rsp_data.red_out == rsp_data.green_out && rsp_data.green_out == rsp_data.blue_out,
      "grey output channels differ")

endmodule

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench;
   import pigg_pkg::*;

   // Must match the parameter of the block under test.
   localparam int unsigned LUMA_FRAC_BITS = 16;

   // The package names only three modes; the fourth code behaves like pass-through.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Cycles to let pass after the last result before the mode changes or the run ends.
   // This is comfortably more than the thirteen-stage pipeline.
   localparam int unsigned SETTLE_CYCLES = 24;

   // The watchdog gives up after this many cycles in which neither channel moves an item.
   localparam int unsigned STUCK_LIMIT = 2000;

   localparam int unsigned ITEMS_PER_PHASE = 240;

   // Predicts the edited pixel for every accepted item and checks that the results
   // come back in order. It holds its own copy of the mode register.
   class edited_pixel_scoreboard;
      logic [1:0]       mode;
      pigg_pix_out_type expected_pixels[$];
      int unsigned      mismatches;

      function new();
         mode       = MODE_PASS;
         mismatches = 0;
      endfunction

      // True when the curve's power-law part at y, times 255, reaches the grey level.
      // Both sides are raised to the twelfth power so that the 1/2.4 exponent vanishes.
      function bit curve_reaches(longint unsigned y, int unsigned level);
         logic [319:0] lhs;
         logic [319:0] rhs;
         begin
            lhs = 320'd1;
            rhs = 320'd1;
            repeat (5) lhs = lhs * y;
            repeat (12) lhs = lhs * 320'd10761;
            repeat (12) rhs = rhs * (40 * level + 561);
            repeat (5) rhs = rhs * (64'd1 << LUMA_FRAC_BITS);
            return lhs >= rhs;
         end
      endfunction

      function logic [7:0] gray_level(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         longint unsigned weighted;
         longint unsigned y;
         int unsigned     lo;
         int unsigned     hi;
         int unsigned     mid;
         begin
            weighted = 64'd2126 * r + 64'd7152 * g + 64'd722 * b;
            y        = (weighted << LUMA_FRAC_BITS) / 64'd2550000;
            if (y * 64'd10000000 <= (64'd31308 << LUMA_FRAC_BITS)) begin
               return 8'((64'd32946 * y) / (64'd10 << LUMA_FRAC_BITS));
            end
            lo = 0;
            hi = 255;
            while (lo < hi) begin
               mid = (lo + hi + 1) / 2;
               if (curve_reaches(y, mid)) begin
                  lo = mid;
               end else begin
                  hi = mid - 1;
               end
            end
            return 8'(lo);
         end
      endfunction

      function pigg_pix_out_type edit_pixel(pigg_pix_in_type px);
         pigg_pix_out_type edited;
         logic [7:0]       level;
         begin
            case (mode)
               MODE_INVERT: begin
                  edited = '{~px.red, ~px.green, ~px.blue};
               end
               MODE_GRAY: begin
                  level  = gray_level(px.red, px.green, px.blue);
                  edited = '{level, level, level};
               end
               default: begin
                  edited = '{px.red, px.green, px.blue};
               end
            endcase
            return edited;
         end
      endfunction

      function void note_pixel(pigg_pix_in_type px);
         expected_pixels.push_back(edit_pixel(px));
      endfunction

      function void check_pixel(pigg_pix_out_type got);
         pigg_pix_out_type want;
         begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel %h with none outstanding", got);
               mismatches++;
               return;
            end
            want = expected_pixels.pop_front();
            if (got !== want) begin
               mismatches++;
            end
            if (got.red_out !== want.red_out) begin
               $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
            end
            if (got.green_out !== want.green_out) begin
               $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
            end
            if (got.blue_out !== want.blue_out) begin
               $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction
   endclass

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   pigg_pix_in_type  req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   pigg_pix_out_type rsp_data;
   logic             csr_wr_en;
   logic [1:0]       csr_wr_data;

   edited_pixel_scoreboard pixel_checker;

   // Items left in the current burst of the sender.
   int unsigned burst_left;

   stall_style_type stall_style;
   int unsigned     stall_style_left;
   int unsigned     stall_tick;
   int unsigned     stuck_cycles;

   pixel_invert_or_gamma_grayscale #(
      .LUMA_FRAC_BITS(LUMA_FRAC_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // The result side. Every result is checked against the values sampled at the edge,
   // and the stall for the next edge follows a style that is drawn anew when its random
   // run ends: no stall at all, occasional stalls, mostly stalled, or a regular beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         pixel_checker.check_pixel(rsp_data);
      end
      stall_tick <= stall_tick + 1;
      if (stall_style_left == 0) begin
         stall_style      <= stall_style_type'($urandom_range(0, 3));
         stall_style_left <= $urandom_range(16, 96);
      end else begin
         stall_style_left <= stall_style_left - 1;
      end
      case (stall_style)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_LIGHT: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         STALL_HEAVY: begin
            rsp_stall <= ($urandom_range(0, 9) < 7);
         end
         default: begin
            rsp_stall <= (stall_tick % 5 < 2);
         end
      endcase
   end

   // The watchdog counts cycles in which no item moves on either channel. Deliberate
   // pauses in the stimulus are far shorter than the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Offers one pixel and returns at the edge where it is taken. The sender works in
   // bursts: when one runs out it may drop valid for a random gap before the next
   // starts, and a gap of none joins two bursts into a longer stretch.
   task automatic send_pixel(input pigg_pix_in_type px);
      int unsigned gap;
      begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 48);
         end
         burst_left--;
         req_valid <= 1'b1;
         req_data  <= px;
         do @(posedge clock); while (req_stall);
         pixel_checker.note_pixel(px);
      end
   endtask

   // Holds the sender back until every outstanding result has come out, then lets the
   // pipeline settle so that a mode change cannot catch an item in flight.
   task automatic wait_for_idle();
      begin
         req_valid <= 1'b0;
         burst_left = 0;
         while (pixel_checker.pending() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
   endtask

   task automatic set_mode(input logic [1:0] mode);
      begin
         csr_wr_en   <= 1'b1;
         csr_wr_data <= mode;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         pixel_checker.mode = mode;
      end
   endtask

   // Mostly uniform pixels, with some corner colours and some very dark ones. The dark
   // ones land on the linear toe of the curve and around the point where it turns into
   // the power law.
   function automatic pigg_pix_in_type random_pixel();
      pigg_pix_in_type px;
      int unsigned     kind;
      begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end else if (kind <= 2) begin
            px.red   = 8'($urandom_range(0, 15));
            px.green = 8'($urandom_range(0, 3));
            px.blue  = 8'($urandom_range(0, 15));
         end else begin
            px = pigg_pix_in_type'(24'($urandom_range(0, 24'hFFFFFF)));
         end
         return px;
      end
   endfunction

   task automatic send_list(input pigg_pix_in_type pixels[$]);
      begin
         foreach (pixels[i]) send_pixel(pixels[i]);
      end
   endtask

   initial begin
      // The first set runs on the mode left by reset, so nothing is written before it.
      pigg_pix_in_type pass_cases[$]   = '{24'h000000, 24'hFFFFFF, 24'hAA55AA};
      pigg_pix_in_type invert_cases[$] = '{24'h000000, 24'hFFFFFF, 24'h55AA55, 24'h80017F};
      // Black and white, each primary at full scale, dark pixels on the linear part of
      // the curve, and a few greys above the point where the power law takes over.
      pigg_pix_in_type gray_cases[$]   = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                                           24'h0000FF, 24'h010000, 24'h000100, 24'h00000B,
                                           24'h030000, 24'h010101, 24'h808080, 24'h0A0A0A};
      pigg_pix_in_type unused_cases[$] = '{24'h123456, 24'hFFFFFF, 24'h000000};
      logic [1:0]      random_modes[8] = '{MODE_GRAY, MODE_INVERT, MODE_PASS, MODE_GRAY,
                                           MODE_UNUSED, MODE_GRAY, MODE_INVERT, MODE_GRAY};

      pixel_checker    = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      rsp_stall        <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= MODE_PASS;
      burst_left       = 0;
      stall_style      <= STALL_NONE;
      stall_style_left <= 0;
      stall_tick       <= 0;
      stuck_cycles     <= 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_list(pass_cases);
      wait_for_idle();
      set_mode(MODE_INVERT);
      send_list(invert_cases);
      wait_for_idle();
      set_mode(MODE_GRAY);
      send_list(gray_cases);
      wait_for_idle();
      set_mode(MODE_UNUSED);
      send_list(unused_cases);

      // Each random phase starts from an empty pipeline, so the sender always pauses
      // for the last result before the mode is changed.
      foreach (random_modes[p]) begin
         wait_for_idle();
         set_mode(random_modes[p]);
         repeat (ITEMS_PER_PHASE) send_pixel(random_pixel());
      end

      wait_for_idle();
      if (pixel_checker.pending() != 0) begin
         $error("%0d edited pixels never arrived", pixel_checker.pending());
      end
      if (pixel_checker.mismatches == 0 && pixel_checker.pending() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
